/* sv/flx_pkg.sv */
// flx_pkg: shared types, codes and character helpers for the filter rule lexer
// used by flx_front, flx_queue, flx_back and filter_rule_lexer
// no dependencies
package flx_pkg;

	localparam int KIND_W  = 5;
	localparam int START_W = 16;
	localparam int LEN_W   = 8;
	localparam int WIN_W   = 40;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_DASH
	} flx_mode_t;

	localparam logic [KIND_W-1:0] K_HASH   = 5'd0;
	localparam logic [KIND_W-1:0] K_EQ     = 5'd1;
	localparam logic [KIND_W-1:0] K_LPAREN = 5'd2;
	localparam logic [KIND_W-1:0] K_RPAREN = 5'd3;
	localparam logic [KIND_W-1:0] K_SEMI   = 5'd4;
	localparam logic [KIND_W-1:0] K_ARROW  = 5'd5;
	localparam logic [KIND_W-1:0] K_IDENT  = 5'd6;
	localparam logic [KIND_W-1:0] K_NUMBER = 5'd7;
	localparam logic [KIND_W-1:0] K_U8     = 5'd8;
	localparam logic [KIND_W-1:0] K_U16    = 5'd9;
	localparam logic [KIND_W-1:0] K_CONST  = 5'd10;
	localparam logic [KIND_W-1:0] K_CASE   = 5'd11;
	localparam logic [KIND_W-1:0] K_DROP   = 5'd12;
	localparam logic [KIND_W-1:0] K_PASS   = 5'd13;
	localparam logic [KIND_W-1:0] K_END    = 5'd14;
	localparam logic [KIND_W-1:0] K_EOF    = 5'd15;
	localparam logic [KIND_W-1:0] K_ERROR  = 5'd16;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_GT     = 8'h3E;

	// keyword patterns, right aligned in the window
	localparam logic [WIN_W-1:0] KW_U8    = 40'h00_0000_7538;
	localparam logic [WIN_W-1:0] KW_U16   = 40'h00_0075_3136;
	localparam logic [WIN_W-1:0] KW_CONST = 40'h63_6F6E_7374;
	localparam logic [WIN_W-1:0] KW_CASE  = 40'h00_6361_7365;
	localparam logic [WIN_W-1:0] KW_DROP  = 40'h00_6472_6F70;
	localparam logic [WIN_W-1:0] KW_PASS  = 40'h00_7061_7373;
	localparam logic [WIN_W-1:0] KW_END   = 40'h00_0065_6E64;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} flx_tok_t;

	// one queue entry holds every token of one input beat
	typedef struct packed {
		logic     two;
		flx_tok_t a;
		flx_tok_t b;
	} flx_ent_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [KIND_W-1:0] kw_kind(input logic [WIN_W-1:0] w,
			input logic [LEN_W-1:0] n);
		logic [KIND_W-1:0] k;
		k = K_IDENT;
		if (n == 8'd2 && w == KW_U8) begin
			k = K_U8;
		end else if (n == 8'd3 && w == KW_U16) begin
			k = K_U16;
		end else if (n == 8'd5 && w == KW_CONST) begin
			k = K_CONST;
		end else if (n == 8'd4 && w == KW_CASE) begin
			k = K_CASE;
		end else if (n == 8'd4 && w == KW_DROP) begin
			k = K_DROP;
		end else if (n == 8'd4 && w == KW_PASS) begin
			k = K_PASS;
		end else if (n == 8'd3 && w == KW_END) begin
			k = K_END;
		end
		return k;
	endfunction

endpackage

/* sv/flx_front.sv */
// flx_front: classifies each text beat, holds the scanning state and builds
// the tokens that the beat causes; depends on flx_pkg
module flx_front #(
	parameter int MAX_TOKEN_LEN = 255,
	parameter int POSITION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       text_byte,
	input  logic             end_of_text,
	input  logic             accept,
	output logic             push,
	output flx_pkg::flx_ent_t ent
);
	import flx_pkg::*;

	localparam int LEN_CAP_I = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_I[LEN_W-1:0];

	flx_mode_t                mode_q, mode_d;
	logic [LEN_W-1:0]         len_q, len_d;
	logic [POSITION_BITS-1:0] rstart_q, rstart_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [WIN_W-1:0]         win_q, win_d;

	logic [POSITION_BITS+START_W-1:0] pos_ext, rstart_ext;
	logic [START_W-1:0] pos16, rstart16;
	logic [LEN_W-1:0]   len_inc;
	logic               flush_hit, fv, sv;
	flx_tok_t           ft, st;

	assign pos_ext    = {{START_W{1'b0}}, pos_q};
	assign rstart_ext = {{START_W{1'b0}}, rstart_q};
	assign pos16      = pos_ext[START_W-1:0];
	assign rstart16   = rstart_ext[START_W-1:0];
	assign len_inc    = (len_q < LEN_CAP) ? len_q + 8'd1 : len_q;
	assign flush_hit  = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			len_q    <= '0;
			rstart_q <= '0;
			pos_q    <= '0;
			win_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			len_q    <= len_d;
			rstart_q <= rstart_d;
			pos_q    <= pos_d;
			win_q    <= win_d;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		len_d    = len_q;
		rstart_d = rstart_q;
		pos_d    = pos_q;
		win_d    = win_q;
		fv       = 1'b0;
		sv       = 1'b0;
		ft.kind  = (mode_q == MODE_IDENT) ? kw_kind(win_q, len_q) : K_NUMBER;
		ft.start = rstart16;
		ft.len   = len_q;
		st.kind  = K_ERROR;
		st.start = pos16;
		st.len   = 8'd1;
		if (end_of_text) begin
			fv       = flush_hit;
			sv       = 1'b1;
			st.kind  = K_EOF;
			st.len   = '0;
			mode_d   = MODE_IDLE;
			len_d    = '0;
			rstart_d = '0;
			pos_d    = '0;
			win_d    = '0;
		end else begin
			pos_d = pos_q + 1'b1;
			if (mode_q == MODE_DASH) begin
				// the byte after a dash is always consumed
				mode_d = MODE_IDLE;
				if (text_byte == CH_GT) begin
					sv       = 1'b1;
					st.kind  = K_ARROW;
					st.start = rstart16;
					st.len   = 8'd2;
				end
			end else if (mode_q == MODE_IDENT &&
					(is_letter(text_byte) || is_digit(text_byte))) begin
				len_d = len_inc;
				win_d = {win_q[WIN_W-9:0], text_byte};
			end else if (mode_q == MODE_NUMBER && is_digit(text_byte)) begin
				len_d = len_inc;
			end else begin
				// run ends here, then the byte is taken as if from idle
				fv     = flush_hit;
				mode_d = MODE_IDLE;
				case (text_byte)
					CH_HASH: begin
						sv      = 1'b1;
						st.kind = K_HASH;
					end
					CH_EQ: begin
						sv      = 1'b1;
						st.kind = K_EQ;
					end
					CH_LPAREN: begin
						sv      = 1'b1;
						st.kind = K_LPAREN;
					end
					CH_RPAREN: begin
						sv      = 1'b1;
						st.kind = K_RPAREN;
					end
					CH_SEMI: begin
						sv      = 1'b1;
						st.kind = K_SEMI;
					end
					CH_DASH: begin
						mode_d   = MODE_DASH;
						rstart_d = pos_q;
					end
					default: begin
						if (is_space(text_byte) || text_byte == CH_GT) begin
							sv = 1'b0;
						end else if (is_letter(text_byte)) begin
							mode_d   = MODE_IDENT;
							rstart_d = pos_q;
							len_d    = 8'd1;
							win_d    = {32'b0, text_byte};
						end else if (is_digit(text_byte)) begin
							mode_d   = MODE_NUMBER;
							rstart_d = pos_q;
							len_d    = 8'd1;
							win_d    = {32'b0, text_byte};
						end else begin
							sv = 1'b1;
						end
					end
				endcase
			end
		end
	end

	assign push    = accept && (fv || sv);
	assign ent.two = fv && sv;
	assign ent.a   = fv ? ft : st;
	assign ent.b   = st;

endmodule

/* sv/flx_queue.sv */
// flx_queue: short first-in first-out queue of token groups between the
// front and the back of the lexer; depends on flx_pkg
module flx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  flx_pkg::flx_ent_t wdata,
	input  logic              pop,
	output flx_pkg::flx_ent_t rdata,
	output logic              full,
	output logic              empty
);
	import flx_pkg::*;

	flx_ent_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q, rptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a write");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != QCNT_W'(QDEPTH)) |-> (wptr_q - rptr_q) == cnt_q[QPTR_W-1:0])
		else $error("queue pointers disagree with count");
`endif

endmodule

/* sv/flx_back.sv */
// flx_back: takes token groups from the queue and sends them one token per
// beat through a registered output stage; depends on flx_pkg
module flx_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  flx_pkg::flx_ent_t            head,
	input  logic                         empty,
	output logic                         pop,
	output logic                         token_valid,
	input  logic                         token_ready,
	output logic [flx_pkg::KIND_W-1:0]   token_kind,
	output logic [flx_pkg::START_W-1:0]  token_start,
	output logic [flx_pkg::LEN_W-1:0]    token_length,
	output logic                         last_of_run
);
	import flx_pkg::*;

	logic     valid_q, pend_q, last_q, load;
	flx_tok_t tok_q;

	// output register may refill whenever it is empty or being drained
	assign load = !valid_q || token_ready;
	assign pop  = load && !empty && (pend_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				pend_q <= !pend_q && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			tok_q  <= pend_q ? head.b : head.a;
			last_q <= pend_q || !head.two;
		end
	end

	assign token_valid  = valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.len;
	assign last_of_run  = last_q;

`ifndef SYNTHESIS
	a_pend_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !empty)
		else $error("second token pending with no group at head");

	a_pend_then_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && pend_q) |=> valid_q && last_q)
		else $error("second token of a group not marked last");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q && last_q)
		else $error("group retired without its last token");
`endif

endmodule

/* sv/filter_rule_lexer.sv */
// filter_rule_lexer: top level of the byte-serial filter rule tokenizer
// instantiates flx_front, flx_queue and flx_back; depends on flx_pkg
//
//  channel  dir  handshake                 beat contents
//  text     in   text_valid / text_ready   text_byte, end_of_text
//  token    out  token_valid / token_ready token_kind, token_start,
//                                          token_length, last_of_run
//
// one text beat is taken every cycle while the four-group queue has room
// a beat's first token is written into the queue and then loaded into the output
// register before it shows on the token port
// a beat that makes two tokens is sent as two token beats, so a long stretch
// of such beats is held back by the token side once the queue fills
// text and token sides stall independently through the queue
// arst_n clears the scanning state, the queue and the output register
module filter_rule_lexer #(
	parameter int MAX_TOKEN_LEN = 255,
	parameter int POSITION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         text_valid,
	output logic                         text_ready,
	input  logic [7:0]                   text_byte,
	input  logic                         end_of_text,
	output logic                         token_valid,
	input  logic                         token_ready,
	output logic [flx_pkg::KIND_W-1:0]   token_kind,
	output logic [flx_pkg::START_W-1:0]  token_start,
	output logic [flx_pkg::LEN_W-1:0]    token_length,
	output logic                         last_of_run
);
	import flx_pkg::*;

	logic     accept, push, pop, full, empty;
	flx_ent_t wr_ent, head;

	assign text_ready = !full;
	assign accept     = text_valid && text_ready;

	flx_front #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
		.POSITION_BITS (POSITION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.accept      (accept),
		.push        (push),
		.ent         (wr_ent)
	);

	flx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_ent),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	flx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule
